### src/rycc_pkg.sv
// Types and fixed-point weights shared by the RGB to YCbCr 4:2:0 block.
package rycc_pkg;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } rycc_in_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } rycc_out_t;

  // one pixel, as the lanes see it
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rycc_pix_t;

  localparam int PIX_NUM    = 4;
  localparam int PIPE_DEPTH = 4;

  // luma weights, unsigned
  localparam logic [23:0] LUMA_R_W     = 24'h008819;
  localparam logic [23:0] LUMA_G_W     = 24'h00810F;
  localparam logic [23:0] LUMA_B_W     = 24'h00CF8F;
  localparam logic [23:0] LUMA_ROUND   = 24'h008000;
  localparam logic [7:0]  LUMA_OFFSET  = 8'd16;

  // chroma weights, signed
  localparam logic signed [24:0] CB_R_W = -25'sd19428;
  localparam logic signed [24:0] CB_G_W = -25'sd19070;
  localparam logic signed [24:0] CB_B_W =  25'sd28528;
  localparam logic signed [24:0] CR_R_W =  25'sd28528;
  localparam logic signed [24:0] CR_G_W = -25'sd24103;
  localparam logic signed [24:0] CR_B_W = -25'sd18724;
  localparam logic signed [27:0] CHROMA_ROUND  = 28'sh0020000;
  localparam logic [7:0]         CHROMA_OFFSET = 8'd128;

endpackage

### src/rycc_luma.sv
// Four-stage luma lane for one pixel.
module rycc_luma import rycc_pkg::*; (
  input  logic       clk,
  input  rycc_pix_t  pix,
  output logic [7:0] luma
);

  logic [23:0] prod_r_r, prod_g_r, prod_b_r;
  logic [22:0] part_r;
  logic [23:0] prod_g2_r;
  logic [23:0] acc_r;
  logic [7:0]  luma_r;

  logic [23:0] prod_r_nxt, prod_g_nxt, prod_b_nxt;
  logic [23:0] part_sum;
  logic [22:0] part_nxt;
  logic [23:0] acc_nxt;
  logic [7:0]  luma_nxt;

  always_comb begin
    prod_r_nxt = LUMA_R_W * {16'd0, pix.red};
    prod_g_nxt = LUMA_G_W * {16'd0, pix.green};
    prod_b_nxt = LUMA_B_W * {16'd0, pix.blue};
    part_sum   = prod_r_r + {2'b00, prod_b_r[23:2]};
    part_nxt   = part_sum[23:1];
    acc_nxt    = {1'b0, part_r} + prod_g2_r + LUMA_ROUND;
    luma_nxt   = acc_r[23:16] + LUMA_OFFSET;
  end

  always_ff @(posedge clk) begin
    prod_r_r  <= prod_r_nxt;
    prod_g_r  <= prod_g_nxt;
    prod_b_r  <= prod_b_nxt;
    part_r    <= part_nxt;
    prod_g2_r <= prod_g_r;
    acc_r     <= acc_nxt;
    luma_r    <= luma_nxt;
  end

  assign luma = luma_r;

endmodule

### src/rycc_chroma.sv
// Four-stage Cb/Cr path: products, per-pixel terms, pair sums, total and scale.
module rycc_chroma import rycc_pkg::*; (
  input  logic       clk,
  input  rycc_pix_t  pix [PIX_NUM],
  output logic [7:0] chroma_blue,
  output logic [7:0] chroma_red
);

  logic signed [24:0] cb_pr_r [PIX_NUM];
  logic signed [24:0] cb_pg_r [PIX_NUM];
  logic signed [24:0] cb_pb_r [PIX_NUM];
  logic signed [24:0] cr_pr_r [PIX_NUM];
  logic signed [24:0] cr_pg_r [PIX_NUM];
  logic signed [24:0] cr_pb_r [PIX_NUM];
  logic signed [24:0] cb_term_r [PIX_NUM];
  logic signed [24:0] cr_term_r [PIX_NUM];
  logic signed [25:0] cb_pair_r [2];
  logic signed [25:0] cr_pair_r [2];
  logic [7:0]         cb_r, cr_r;

  logic signed [24:0] cb_term_nxt [PIX_NUM];
  logic signed [24:0] cr_term_nxt [PIX_NUM];
  logic signed [25:0] cb_pair_nxt [2];
  logic signed [25:0] cr_pair_nxt [2];
  logic signed [27:0] cb_tot, cr_tot;
  logic [7:0]         cb_nxt, cr_nxt;

  always_ff @(posedge clk) begin
    for (int p = 0; p < PIX_NUM; p++) begin
      cb_pr_r[p] <= $signed({17'd0, pix[p].red})   * CB_R_W;
      cb_pg_r[p] <= $signed({17'd0, pix[p].green}) * CB_G_W;
      cb_pb_r[p] <= $signed({17'd0, pix[p].blue})  * CB_B_W;
      cr_pr_r[p] <= $signed({17'd0, pix[p].red})   * CR_R_W;
      cr_pg_r[p] <= $signed({17'd0, pix[p].green}) * CR_G_W;
      cr_pb_r[p] <= $signed({17'd0, pix[p].blue})  * CR_B_W;
    end
  end

  // arithmetic shifts floor, matching the term definitions
  always_comb begin
    for (int p = 0; p < PIX_NUM; p++) begin
      cb_term_nxt[p] = (cb_pr_r[p] >>> 1) + cb_pg_r[p] + cb_pb_r[p];
      cr_term_nxt[p] = cr_pr_r[p] + cr_pg_r[p] + (cr_pb_r[p] >>> 2);
    end
    for (int k = 0; k < 2; k++) begin
      cb_pair_nxt[k] = 26'(cb_term_r[2*k]) + 26'(cb_term_r[2*k+1]);
      cr_pair_nxt[k] = 26'(cr_term_r[2*k]) + 26'(cr_term_r[2*k+1]);
    end
    cb_tot = 28'(cb_pair_r[0]) + 28'(cb_pair_r[1]) + CHROMA_ROUND;
    cr_tot = 28'(cr_pair_r[0]) + 28'(cr_pair_r[1]) + CHROMA_ROUND;
    cb_nxt = cb_tot[25:18] + CHROMA_OFFSET;
    cr_nxt = cr_tot[25:18] + CHROMA_OFFSET;
  end

  always_ff @(posedge clk) begin
    cb_term_r <= cb_term_nxt;
    cr_term_r <= cr_term_nxt;
    cb_pair_r <= cb_pair_nxt;
    cr_pair_r <= cr_pair_nxt;
    cb_r      <= cb_nxt;
    cr_r      <= cr_nxt;
  end

  assign chroma_blue = cb_r;
  assign chroma_red  = cr_r;

endmodule

### src/rgb_to_ycbcr_420_block.sv
// Top level: 2x2 RGB block to four Y bytes plus one Cb and one Cr byte.
//
//  channel | ports                      | transfer
//  --------+----------------------------+------------------------------------
//  input   | start, busy, in_data       | start high and busy low at clk edge
//  result  | out_valid, out_data        | out_valid high for one cycle
//
// One block per cycle, through registered steps: products, per-pixel terms,
// luma add / chroma pair sums, then round, shift and offset.
// busy stays low; the pipeline never stalls since the receiver cannot.
// rst_n (synchronous) clears only the valid bits; data registers are free.
module rgb_to_ycbcr_420_block import rycc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rycc_in_t  in_data,
  output logic      out_valid,
  output rycc_out_t out_data
);

  rycc_pix_t             pix [PIX_NUM];
  logic [7:0]            luma [PIX_NUM];
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  assign busy = 1'b0;

  assign pix[0] = '{red: in_data.red_top_left, green: in_data.green_top_left,
                    blue: in_data.blue_top_left};
  assign pix[1] = '{red: in_data.red_top_right, green: in_data.green_top_right,
                    blue: in_data.blue_top_right};
  assign pix[2] = '{red: in_data.red_bottom_left, green: in_data.green_bottom_left,
                    blue: in_data.blue_bottom_left};
  assign pix[3] = '{red: in_data.red_bottom_right, green: in_data.green_bottom_right,
                    blue: in_data.blue_bottom_right};

  for (genvar p = 0; p < PIX_NUM; p++) begin : g_luma
    rycc_luma u_luma (
      .clk  (clk),
      .pix  (pix[p]),
      .luma (luma[p])
    );
  end

  rycc_chroma u_chroma (
    .clk         (clk),
    .pix         (pix),
    .chroma_blue (out_data.chroma_blue),
    .chroma_red  (out_data.chroma_red)
  );

  assign out_data.luma_top_left     = luma[0];
  assign out_data.luma_top_right    = luma[1];
  assign out_data.luma_bottom_left  = luma[2];
  assign out_data.luma_bottom_right = luma[3];

  // valid bit follows each transaction through the stages
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

endmodule

### bench/rgb_to_ycbcr_420_block_tb.sv
// Self-checking testbench for the 2x2 RGB to YCbCr 4:2:0 block: directed and random blocks.
module rgb_to_ycbcr_420_block_tb import rycc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point weights, kept independent of the package
  localparam bit [31:0] Y_R_W      = 32'h8819;
  localparam bit [31:0] Y_G_W      = 32'h810F;
  localparam bit [31:0] Y_B_W      = 32'hCF8F;
  localparam bit [31:0] Y_RND      = 32'h8000;
  localparam bit [31:0] Y_OFS      = 32'd16;
  localparam longint    CB_R       = -19428;
  localparam longint    CB_G       = -19070;
  localparam longint    CB_B       = 28528;
  localparam longint    CR_R       = 28528;
  localparam longint    CR_G       = -24103;
  localparam longint    CR_B       = -18724;
  localparam longint    C_RND      = 'h20000;
  localparam longint    C_OFS      = 128;
  localparam int        LATENCY    = 4;
  localparam int        STALL_MAX  = 200;
  localparam int        BURST_LEN  = 50;
  localparam int        NUM_BURSTS = 38;

  class ycc_scoreboard;
    rycc_out_t   expected_q[$];
    int unsigned errors;
    string       field_name[6];

    function new();
      errors = 0;
      field_name = '{"chroma_red", "chroma_blue", "luma_bottom_right",
                     "luma_bottom_left", "luma_top_right", "luma_top_left"};
    endfunction

    function logic [7:0] pixel_luma(rycc_pix_t px);
      bit [31:0] acc;
      acc = ((Y_R_W * px.red) + ((Y_B_W * px.blue) >> 2)) >> 1;
      acc = (acc + Y_G_W * px.green + Y_RND) >> 16;
      acc = acc + Y_OFS;
      return acc[7:0];
    endfunction

    // floor shift, low byte kept (no saturation)
    function logic [7:0] chroma_byte(longint sum);
      longint v;
      v = C_OFS + ((sum + C_RND) >>> 18);
      return v[7:0];
    endfunction

    function rycc_out_t convert(rycc_in_t blk);
      rycc_pix_t px;
      rycc_out_t res;
      longint    r, g, b, cb_sum, cr_sum;
      cb_sum = 0;
      cr_sum = 0;
      for (int p = 0; p < 4; p++) begin
        px = blk[24*(3-p) +: 24];
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        res[8*(5-p) +: 8] = pixel_luma(px);
        cb_sum += ((CB_R * r) >>> 1) + CB_G * g + CB_B * b;
        cr_sum += CR_R * r + CR_G * g + ((CR_B * b) >>> 2);
      end
      res.chroma_blue = chroma_byte(cb_sum);
      res.chroma_red  = chroma_byte(cr_sum);
      return res;
    endfunction

    function void note_block(rycc_in_t blk);
      expected_q.push_back(convert(blk));
    endfunction

    function void check_result(rycc_out_t got);
      rycc_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h with no transaction pending", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[8*i +: 8] !== want[8*i +: 8]) begin
          $display("%0t: %s expected %h actual %h", $time, field_name[i],
                   want[8*i +: 8], got[8*i +: 8]);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  rycc_in_t  in_data;
  logic      out_valid;
  rycc_out_t out_data;

  ycc_scoreboard sb;
  int            idle_cycles;

  rgb_to_ycbcr_420_block DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // transaction monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_block(in_data);
      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("rgb_to_ycbcr_420_block_tb: FAIL");
        $finish;
      end
    end
  end

  // start stays high across back-to-back blocks
  task automatic send_block(input rycc_in_t blk, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic rycc_in_t uniform_block(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {4{r, g, b}};
  endfunction

  function automatic logic [7:0] extreme_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'hFE;
      4:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic rycc_in_t random_block();
    rycc_in_t  blk;
    rycc_pix_t base;
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < 12; i++) blk[8*i +: 8] = extreme_byte();
      1: begin
        // smooth image area: small spread around one color
        base = 24'($urandom);
        for (int i = 0; i < 12; i++)
          blk[8*i +: 8] = base[8*(i%3) +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
      end
      default: for (int i = 0; i < 12; i++) blk[8*i +: 8] = 8'($urandom);
    endcase
    return blk;
  endfunction

  initial begin
    rycc_in_t directed_q[$];
    rycc_in_t blk;
    int       mode;
    int       gap;

    sb          = new();
    idle_cycles = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    directed_q.push_back(uniform_block(8'h00, 8'h00, 8'h00));
    directed_q.push_back(uniform_block(8'hFF, 8'hFF, 8'hFF));
    directed_q.push_back(uniform_block(8'hAA, 8'hAA, 8'hAA));
    directed_q.push_back(uniform_block(8'h55, 8'h55, 8'h55));
    directed_q.push_back(uniform_block(8'hFF, 8'h00, 8'h00));
    directed_q.push_back(uniform_block(8'h00, 8'hFF, 8'h00));
    directed_q.push_back(uniform_block(8'h00, 8'h00, 8'hFF));
    // most negative Cb and Cr sums, then positive mixes
    directed_q.push_back(uniform_block(8'hFF, 8'hFF, 8'h00));
    directed_q.push_back(uniform_block(8'h00, 8'hFF, 8'hFF));
    directed_q.push_back(uniform_block(8'hFF, 8'h00, 8'hFF));
    for (int p = 0; p < 4; p++) begin
      blk = '0;
      blk[24*(3-p) +: 24] = 24'hFFFFFF;
      directed_q.push_back(blk);
      directed_q.push_back(~blk);
    end
    for (int i = 0; i < 12; i++) blk[8*i +: 8] = 8'(i * 23 + 7);
    directed_q.push_back(blk);
    directed_q.push_back(~blk);

    foreach (directed_q[i])
      send_block(directed_q[i], (i < 8) ? 0 : $urandom_range(0, 15));

    for (int n = 0; n < NUM_BURSTS; n++) begin
      mode = $urandom_range(0, 2);
      for (int k = 0; k < BURST_LEN; k++) begin
        case (mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 15);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        endcase
        send_block(random_block(), gap);
      end
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0) begin
      $display("rgb_to_ycbcr_420_block_tb: PASS");
    end else begin
      $display("rgb_to_ycbcr_420_block_tb: FAIL");
    end
    $finish;
  end

endmodule

### rgb_to_ycbcr_420_block.f
src/rycc_pkg.sv
src/rycc_luma.sv
src/rycc_chroma.sv
src/rgb_to_ycbcr_420_block.sv
bench/rgb_to_ycbcr_420_block_tb.sv
